### rtl/core/stream_tagged_response_queue_core_defines.svh
`ifndef STREAM_TAGGED_RESPONSE_QUEUE_CORE_DEFINES_SVH
`define STREAM_TAGGED_RESPONSE_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define STRQ_ASSERT_SAME(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("strq: same-cycle property failed");

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define STRQ_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("strq: next-cycle property failed");

`endif

### rtl/core/strq_pkg.sv
package strq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TAG_BITS_DEF    = 16;
  localparam int HANDLE_BITS_DEF = 32;

  localparam int CMD_W      = 2;
  localparam int STREAM_W   = 16;
  localparam int HANDLE_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int LEVEL_W    = 7;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic accum;
    logic grab;
    logic move;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ptr_more;
    logic chk_vld;
    logic hit;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/core/strq_ctrl.sv
module strq_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic [strq_pkg::CMD_W-1:0]  in_cmd,
  output logic                        in_tready,
  input  strq_pkg::dp_stat_t          stat,
  output strq_pkg::ctl_cmd_t          cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_cmd == strq_pkg::CMD_GET || in_cmd == strq_pkg::CMD_COUNT) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        cmd.accum = 1'b1;
        if (stat.hit) begin
          // stop reading; the gap closes from the hit onward
          cmd.grab  = 1'b1;
          state_nxt = S_SHIFT;
        end else begin
          cmd.issue = stat.ptr_more;
          if (!stat.ptr_more && !stat.chk_vld) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        cmd.move  = 1'b1;
        cmd.issue = stat.ptr_more;
        if (!stat.ptr_more && !stat.chk_vld) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/strq_dpath.sv
module strq_dpath #(
  parameter int QUEUE_DEPTH = strq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = strq_pkg::TAG_BITS_DEF,
  parameter int HANDLE_BITS = strq_pkg::HANDLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  strq_pkg::ctl_cmd_t             cmd,
  output strq_pkg::dp_stat_t             stat,
  input  logic [strq_pkg::CMD_W-1:0]     in_cmd,
  input  logic [strq_pkg::STREAM_W-1:0]  in_stream,
  input  logic                           in_error,
  input  logic [strq_pkg::HANDLE_W-1:0]  in_handle,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [strq_pkg::STATUS_W-1:0]  out_status,
  output logic [strq_pkg::LEVEL_W-1:0]   out_fill,
  output logic [strq_pkg::LEVEL_W-1:0]   out_count,
  output logic [strq_pkg::HANDLE_W-1:0]  out_handle,
  output logic                           out_error,
  output logic [strq_pkg::STREAM_W-1:0]  out_stream
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = (TAG_BITS < strq_pkg::STREAM_W) ? TAG_BITS : strq_pkg::STREAM_W;
  localparam int HW = (HANDLE_BITS < strq_pkg::HANDLE_W) ? HANDLE_BITS : strq_pkg::HANDLE_W;

  typedef struct packed {
    logic [TW-1:0] tag;
    logic          err;
    logic [HW-1:0] hdl;
  } entry_t;

  entry_t mem [QUEUE_DEPTH];

  logic [CW-1:0]               total_r;
  logic [CW-1:0]               total_nxt;
  logic [CW-1:0]               ptr_r;
  logic [CW-1:0]               cnt_r;
  logic [AW-1:0]               chk_idx_r;
  logic                        chk_vld_r;
  logic                        found_r;
  entry_t                      rd_data_r;
  entry_t                      hit_r;
  entry_t                      req_ent_r;
  logic [strq_pkg::CMD_W-1:0]  req_cmd_r;
  logic                        out_valid_r;

  logic [strq_pkg::STATUS_W-1:0] status_nxt;
  logic [strq_pkg::LEVEL_W-1:0]  count_nxt;
  logic [strq_pkg::HANDLE_W-1:0] hdl_nxt;
  logic                          err_nxt;
  logic [strq_pkg::STREAM_W-1:0] tag_nxt;

  logic [strq_pkg::STATUS_W-1:0] out_status_r;
  logic [strq_pkg::LEVEL_W-1:0]  out_fill_r;
  logic [strq_pkg::LEVEL_W-1:0]  out_count_r;
  logic [strq_pkg::HANDLE_W-1:0] out_handle_r;
  logic                          out_error_r;
  logic [strq_pkg::STREAM_W-1:0] out_stream_r;

  logic          full;
  logic          tag_eq;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  assign full   = (total_r == CW'(QUEUE_DEPTH));
  assign tag_eq = (rd_data_r.tag == req_ent_r.tag);

  assign stat.ptr_more = (ptr_r < total_r);
  assign stat.chk_vld  = chk_vld_r;
  assign stat.hit      = (req_cmd_r == strq_pkg::CMD_GET) && chk_vld_r &&
                         (rd_data_r.err || tag_eq);
  assign stat.out_free = !out_valid_r || out_tready;

  // Shift writes land one slot below the entry just read; a put writes at the tail.
  assign wr_en   = (cmd.move && chk_vld_r) ||
                   (cmd.commit && req_cmd_r == strq_pkg::CMD_PUT && !full);
  assign wr_addr = cmd.move ? (chk_idx_r - AW'(1)) : total_r[AW-1:0];
  assign wr_data = cmd.move ? rd_data_r : req_ent_r;

  always_comb begin
    total_nxt  = total_r;
    status_nxt = strq_pkg::ST_OK;
    count_nxt  = '0;
    hdl_nxt    = '0;
    err_nxt    = 1'b0;
    tag_nxt    = '0;
    case (req_cmd_r)
      strq_pkg::CMD_PUT: begin
        if (full) begin
          status_nxt = strq_pkg::ST_FULL;
        end else begin
          total_nxt = total_r + CW'(1);
        end
      end
      strq_pkg::CMD_GET: begin
        if (found_r) begin
          total_nxt = total_r - CW'(1);
          hdl_nxt   = strq_pkg::HANDLE_W'(hit_r.hdl);
          err_nxt   = hit_r.err;
          tag_nxt   = strq_pkg::STREAM_W'(hit_r.tag);
        end else begin
          status_nxt = strq_pkg::ST_NONE;
        end
      end
      strq_pkg::CMD_COUNT: begin
        count_nxt = strq_pkg::LEVEL_W'(cnt_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      chk_vld_r <= cmd.issue;
      if (cmd.load) begin
        ptr_r   <= '0;
        cnt_r   <= '0;
        found_r <= 1'b0;
      end else if (cmd.grab) begin
        ptr_r   <= CW'(chk_idx_r) + CW'(1);
        found_r <= 1'b1;
      end else if (cmd.issue) begin
        ptr_r <= ptr_r + CW'(1);
      end
      if (cmd.accum && chk_vld_r && tag_eq) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.commit) begin
        total_r <= total_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[ptr_r[AW-1:0]];
      chk_idx_r <= ptr_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd_r     <= in_cmd;
      req_ent_r.tag <= in_stream[TW-1:0];
      req_ent_r.err <= in_error;
      req_ent_r.hdl <= in_handle[HW-1:0];
    end
    if (cmd.grab) begin
      hit_r <= rd_data_r;
    end
    if (cmd.commit) begin
      out_status_r <= status_nxt;
      out_fill_r   <= strq_pkg::LEVEL_W'(total_nxt);
      out_count_r  <= count_nxt;
      out_handle_r <= hdl_nxt;
      out_error_r  <= err_nxt;
      out_stream_r <= tag_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_fill   = out_fill_r;
  assign out_count  = out_count_r;
  assign out_handle = out_handle_r;
  assign out_error  = out_error_r;
  assign out_stream = out_stream_r;

endmodule

### rtl/core/stream_tagged_response_queue_core.sv
// Tagged response queue. Requests enter on the in_ stream: in_tuser carries the
// command (put, get oldest tag match or error entry, count tag matches), in_tdata
// the stream tag, the error flag and the message handle. Each request yields
// exactly one result on the out_ stream: out_tuser carries the status, out_tdata
// the fill level, the match count and, for a get, the removed entry.
// One request is worked at a time. A put (or an unused command) goes from
// acceptance straight to the final step, where the result register loads, and
// the next request waits until then. A get or a count walks the entry memory
// one slot per cycle through its single read port: a count or a miss scans
// every held entry; a hit at slot k stops the scan there, then each later entry
// is moved down one slot to close the gap.
// The next request is accepted the cycle after the result register loads.
// The result sits in an output register; the next request is accepted while it
// waits, and a stalled out_tready only holds the block in its final step.
// Reset empties the queue (fill count to zero) and clears the control state;
// the entry memory itself is not cleared and needs no clearing pass.
module stream_tagged_response_queue_core #(
  parameter int QUEUE_DEPTH = strq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = strq_pkg::TAG_BITS_DEF,
  parameter int HANDLE_BITS = strq_pkg::HANDLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // stream_id[15:0], error_flag[16], message_handle[48:17], zero[55:49]
  input  logic [strq_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd[1:0]
  input  logic [strq_pkg::CMD_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // fill_level[6:0], match_count[13:7], out_handle[45:14], out_error[46],
  // out_stream[62:47], zero[63]
  output logic [strq_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status[1:0]
  output logic [strq_pkg::STATUS_W-1:0]    out_tuser
);

  strq_pkg::ctl_cmd_t ctl_cmd;
  strq_pkg::dp_stat_t dp_stat;

  logic [strq_pkg::LEVEL_W-1:0]  res_fill;
  logic [strq_pkg::LEVEL_W-1:0]  res_count;
  logic [strq_pkg::HANDLE_W-1:0] res_handle;
  logic                          res_error;
  logic [strq_pkg::STREAM_W-1:0] res_stream;

  strq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .stat      (dp_stat),
    .cmd       (ctl_cmd)
  );

  strq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctl_cmd),
    .stat       (dp_stat),
    .in_cmd     (in_tuser),
    .in_stream  (in_tdata[15:0]),
    .in_error   (in_tdata[16]),
    .in_handle  (in_tdata[48:17]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_tuser),
    .out_fill   (res_fill),
    .out_count  (res_count),
    .out_handle (res_handle),
    .out_error  (res_error),
    .out_stream (res_stream)
  );

  assign out_tdata = {1'b0, res_stream, res_error, res_handle, res_count, res_fill};

endmodule

### rtl/core/strq_checker.sv
`include "stream_tagged_response_queue_core_defines.svh"

module strq_checker #(
  parameter int QUEUE_DEPTH = strq_pkg::QUEUE_DEPTH_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [strq_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [strq_pkg::STATUS_W-1:0]    out_tuser
);

  localparam int LVL_W = strq_pkg::LEVEL_W;
  localparam logic [LVL_W-1:0] FULL_LEVEL = LVL_W'(QUEUE_DEPTH);

  logic in_fire;
  logic out_stall;
  logic full_res;
  logic miss_res;

  assign in_fire   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign full_res  = out_tvalid && (out_tuser == strq_pkg::ST_FULL);
  assign miss_res  = out_tvalid && (out_tuser == strq_pkg::ST_NONE);

  // stalled result stays put
  `STRQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable({out_tuser, out_tdata}))

  // one request at a time: busy right after an accept
  `STRQ_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_fire, !in_tready)

  // a dropped put reports a full queue
  `STRQ_ASSERT_SAME(a_full_level, clk, rst_n, full_res, out_tdata[6:0] == FULL_LEVEL)

  // a miss returns no entry
  `STRQ_ASSERT_SAME(a_miss_empty, clk, rst_n, miss_res, out_tdata[62:14] == '0)

endmodule

bind stream_tagged_response_queue_core strq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_strq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### test/stream_tagged_response_queue_core_test.sv
module stream_tagged_response_queue_core_test;

  localparam logic [strq_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int DEPTH = strq_pkg::QUEUE_DEPTH_DEF;
  localparam int CHK_W = strq_pkg::HANDLE_W;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT = 600000;
  localparam int QUIET_FIRST = 350;
  localparam int QUIET_LAST = 500;

  typedef struct {
    logic [strq_pkg::CMD_W-1:0]    cmd;
    logic [strq_pkg::STREAM_W-1:0] stream;
    logic                          err;
    logic [strq_pkg::HANDLE_W-1:0] handle;
    bit                            drain_first;
  } request_t;

  typedef struct {
    logic [strq_pkg::STATUS_W-1:0] status;
    logic [strq_pkg::LEVEL_W-1:0]  fill;
    logic [strq_pkg::LEVEL_W-1:0]  count;
    logic [strq_pkg::HANDLE_W-1:0] handle;
    logic                          err;
    logic [strq_pkg::STREAM_W-1:0] stream;
  } response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [strq_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [strq_pkg::CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [strq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [strq_pkg::STATUS_W-1:0] out_tuser;

  stream_tagged_response_queue_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Shadow copy of the held entries, oldest at slot 0.
  logic [strq_pkg::STREAM_W-1:0] held_tag [DEPTH];
  logic                          held_err [DEPTH];
  logic [strq_pkg::HANDLE_W-1:0] held_hdl [DEPTH];
  int held_total = 0;

  request_t pending_reqs[$];
  response_t expected_resps[$];
  request_t cur_req = '{default: '0};
  bit presenting = 1'b0;
  bit in_taken = 1'b0;
  int accepted_reqs = 0;
  int failures = 0;
  int n_put_ok = 0, n_put_full = 0, n_get_hit = 0, n_get_miss = 0, n_count = 0;
  int peak_fill = 0;
  logic [strq_pkg::STREAM_W-1:0] tag_pool [4];

  wire quiet_window = (accepted_reqs >= QUIET_FIRST) && (accepted_reqs < QUIET_LAST);

  task automatic queue_apply(input request_t rq, output response_t rs);
    int hit;
    rs = '{default: '0};
    rs.status = strq_pkg::ST_OK;
    hit = -1;
    case (rq.cmd)
      strq_pkg::CMD_PUT: begin
        if (held_total >= DEPTH) begin
          rs.status = strq_pkg::ST_FULL;
          n_put_full++;
        end else begin
          held_tag[held_total] = rq.stream;
          held_err[held_total] = rq.err;
          held_hdl[held_total] = rq.handle;
          held_total++;
          n_put_ok++;
        end
      end
      strq_pkg::CMD_GET: begin
        for (int i = 0; i < held_total; i++)
          if (hit < 0 && (held_err[i] || held_tag[i] == rq.stream)) hit = i;
        if (hit < 0) begin
          rs.status = strq_pkg::ST_NONE;
          n_get_miss++;
        end else begin
          rs.handle = held_hdl[hit];
          rs.err = held_err[hit];
          rs.stream = held_tag[hit];
          // close the gap
          for (int i = hit; i < held_total - 1; i++) begin
            held_tag[i] = held_tag[i + 1];
            held_err[i] = held_err[i + 1];
            held_hdl[i] = held_hdl[i + 1];
          end
          held_total--;
          n_get_hit++;
        end
      end
      strq_pkg::CMD_COUNT: begin
        for (int i = 0; i < held_total; i++)
          if (held_tag[i] == rq.stream) rs.count++;
        n_count++;
      end
      default: ;
    endcase
    rs.fill = strq_pkg::LEVEL_W'(held_total);
    if (held_total > peak_fill) peak_fill = held_total;
  endtask

  task automatic check_field(input string name, input logic [CHK_W-1:0] exp_v,
                             input logic [CHK_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      failures++;
    end
  endtask

  task automatic push_req(input logic [strq_pkg::CMD_W-1:0] cmd,
                          input logic [strq_pkg::STREAM_W-1:0] stream,
                          input logic err, input logic [strq_pkg::HANDLE_W-1:0] handle,
                          input bit drain_first = 1'b0);
    request_t rq;
    rq.cmd = cmd;
    rq.stream = stream;
    rq.err = err;
    rq.handle = handle;
    rq.drain_first = drain_first;
    pending_reqs = {pending_reqs, rq};
  endtask

  function automatic logic [strq_pkg::STREAM_W-1:0] pick_tag();
    if ($urandom_range(0, 99) < 75) return tag_pool[$urandom_range(0, 3)];
    return strq_pkg::STREAM_W'($urandom_range(0, 65535));
  endfunction

  // Predict on acceptance, check on delivery.
  always @(posedge clk) begin : monitor_b
    request_t rq;
    response_t rs;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        rq.cmd = in_tuser;
        rq.stream = in_tdata[15:0];
        rq.err = in_tdata[16];
        rq.handle = in_tdata[48:17];
        rq.drain_first = 1'b0;
        queue_apply(rq, rs);
        expected_resps = {expected_resps, rs};
        accepted_reqs++;
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %h/%h",
                   $time, out_tuser, out_tdata);
          failures++;
        end else begin
          rs = expected_resps.pop_front();
          check_field("status", CHK_W'(rs.status), CHK_W'(out_tuser));
          check_field("fill_level", CHK_W'(rs.fill), CHK_W'(out_tdata[6:0]));
          check_field("match_count", CHK_W'(rs.count), CHK_W'(out_tdata[13:7]));
          check_field("out_handle", rs.handle, out_tdata[45:14]);
          check_field("out_error", CHK_W'(rs.err), CHK_W'(out_tdata[46]));
          check_field("out_stream", CHK_W'(rs.stream), CHK_W'(out_tdata[62:47]));
          check_field("reserved", CHK_W'(1'b0), CHK_W'(out_tdata[63]));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (in_taken) begin
      presenting = 1'b0;
      in_taken = 1'b0;
    end
    if (rst_n && !presenting && pending_reqs.size() > 0) begin
      if (pending_reqs[0].drain_first && expected_resps.size() != 0) begin
        // hold until every outstanding response has come back
      end else if (!quiet_window && $urandom_range(0, 99) < 31) begin
      end else begin
        cur_req = pending_reqs.pop_front();
        presenting = 1'b1;
      end
    end
    in_tvalid <= presenting;
    in_tdata <= {7'd0, cur_req.handle, cur_req.err, cur_req.stream};
    in_tuser <= cur_req.cmd;
    out_tready <= rst_n && (quiet_window || $urandom_range(0, 99) >= 31);
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("stream_tagged_response_queue_core_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int n_random;
    int round_len;
    int mode;
    int pick;
    bit first_round;
    logic [strq_pkg::CMD_W-1:0] cmd;
    logic err;

    tag_pool[0] = 16'h0000;
    tag_pool[1] = 16'hFFFF;
    tag_pool[2] = strq_pkg::STREAM_W'($urandom_range(1, 65534));
    tag_pool[3] = strq_pkg::STREAM_W'($urandom_range(1, 65534));

    // empty queue, unused command, field extremes, gap closing, error entries
    push_req(strq_pkg::CMD_GET, 16'h0000, 1'b0, 32'h0);
    push_req(strq_pkg::CMD_COUNT, 16'hFFFF, 1'b1, 32'hFFFFFFFF);
    push_req(CMD_NOP, 16'hFFFF, 1'b1, 32'hFFFFFFFF);
    push_req(strq_pkg::CMD_PUT, 16'h0000, 1'b0, 32'h00000000);
    push_req(strq_pkg::CMD_PUT, 16'hFFFF, 1'b0, 32'hFFFFFFFF);
    push_req(strq_pkg::CMD_PUT, 16'h1234, 1'b0, 32'hA5A5A5A5);
    push_req(strq_pkg::CMD_PUT, 16'hFFFF, 1'b0, 32'h5A5A5A5A);
    push_req(strq_pkg::CMD_COUNT, 16'hFFFF, 1'b0, 32'h0);
    push_req(strq_pkg::CMD_COUNT, 16'h0000, 1'b0, 32'h0);
    push_req(strq_pkg::CMD_GET, 16'hFFFF, 1'b0, 32'h0);
    push_req(strq_pkg::CMD_GET, 16'h7777, 1'b0, 32'h0);
    push_req(strq_pkg::CMD_PUT, 16'h5555, 1'b1, 32'hDEADBEEF);
    push_req(strq_pkg::CMD_PUT, 16'h5555, 1'b0, 32'h01234567);
    push_req(strq_pkg::CMD_COUNT, 16'h5555, 1'b0, 32'h0);
    push_req(strq_pkg::CMD_GET, 16'h9999, 1'b0, 32'h0);
    push_req(strq_pkg::CMD_GET, 16'h0000, 1'b1, 32'hFFFFFFFF);
    push_req(CMD_NOP, 16'h0000, 1'b0, 32'h0);
    push_req(strq_pkg::CMD_GET, 16'h1234, 1'b0, 32'h0);
    push_req(strq_pkg::CMD_GET, 16'hFFFF, 1'b0, 32'h0);
    push_req(strq_pkg::CMD_GET, 16'h5555, 1'b0, 32'h0);
    push_req(strq_pkg::CMD_GET, 16'h5555, 1'b0, 32'h0);

    // Rounds of fills, drains, mixes and noise; the first round fills past full.
    n_random = 0;
    first_round = 1'b1;
    while (n_random < RANDOM_ITEMS) begin
      mode = first_round ? 0 : $urandom_range(0, 3);
      round_len = first_round ? 70 : $urandom_range(5, 60);
      for (int k = 0; k < round_len; k++) begin
        pick = $urandom_range(0, 99);
        case (mode)
          0: cmd = pick < 85 ? strq_pkg::CMD_PUT :
                   (pick < 95 ? strq_pkg::CMD_COUNT : strq_pkg::CMD_GET);
          1: cmd = pick < 75 ? strq_pkg::CMD_GET :
                   (pick < 95 ? strq_pkg::CMD_COUNT : strq_pkg::CMD_PUT);
          2: cmd = pick < 40 ? strq_pkg::CMD_PUT : (pick < 75 ? strq_pkg::CMD_GET :
                   (pick < 92 ? strq_pkg::CMD_COUNT : CMD_NOP));
          default: cmd = strq_pkg::CMD_W'($urandom_range(0, 3));
        endcase
        if (first_round) cmd = strq_pkg::CMD_PUT;
        if (cmd == strq_pkg::CMD_PUT) err = $urandom_range(0, 99) < 6;
        else err = 1'($urandom_range(0, 1));
        push_req(cmd,
                 mode == 3 ? strq_pkg::STREAM_W'($urandom_range(0, 65535)) : pick_tag(),
                 err, $urandom(),
                 k == 0 && (first_round || $urandom_range(0, 9) == 0));
      end
      n_random += round_len;
      first_round = 1'b0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || presenting) @(posedge clk);
    while (expected_resps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Ran %0d requests: %0d puts stored, %0d dropped full, %0d get hits,",
             accepted_reqs, n_put_ok, n_put_full, n_get_hit);
    $display("  %0d get misses, %0d counts, peak fill %0d of %0d.",
             n_get_miss, n_count, peak_fill, DEPTH);
    if (failures == 0) begin
      $display("stream_tagged_response_queue_core_test: PASS");
    end else begin
      $display("stream_tagged_response_queue_core_test: FAIL");
    end
    $finish;
  end

endmodule

### stream_tagged_response_queue_core.f
+incdir+rtl/core
rtl/core/strq_pkg.sv
rtl/core/strq_ctrl.sv
rtl/core/strq_dpath.sv
rtl/core/stream_tagged_response_queue_core.sv
rtl/core/strq_checker.sv
test/stream_tagged_response_queue_core_test.sv
